// ===== hw/rtl/qaf_pkg.sv =====
// Shared types and constants of the quaternion attitude filter.
// No dependencies; the interfaces, qaf_mac, the filter and the test files import it.
`timescale 1ns / 1ps
`default_nettype none

package qaf_pkg;

    // Operand and accumulator widths of the shared multiply-accumulate unit
    localparam int unsigned OPND_W = 33;
    localparam int unsigned PROD_W = 2 * OPND_W;
    localparam int unsigned ACC_W  = PROD_W;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_GAIN = 2'd1;
    localparam logic [1:0] CFG_RUN  = 2'd2;

    // Filter modes; any other code holds the attitude
    localparam logic [1:0] MODE_GYRO = 2'd0;
    localparam logic [1:0] MODE_CORR = 2'd1;

    // Reset value of the proportional gain (1.0 in Q8.8)
    localparam logic [15:0] GAIN_RESET = 16'd256;

    // Sample and attitude types
    typedef logic signed [15:0] t_sample;
    typedef logic signed [31:0] t_comp;

    // One micro-operation of the multiply-accumulate unit
    typedef struct packed {
        logic                     en;    // issue a product this cycle
        logic                     clr;   // start a new sum
        logic                     neg;   // subtract the product
        logic                     sh30;  // floor the product by 2^30 before adding
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } t_mac_op;

endpackage

`default_nettype wire

// ===== hw/rtl/qaf_in_if.sv =====
// Input channel of the attitude filter: one IMU sample and a time step.
// Depends on qaf_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none

interface qaf_in_if;
    import qaf_pkg::*;

    logic        valid;
    logic        ready;
    t_sample     accel_x;
    t_sample     accel_y;
    t_sample     accel_z;
    t_sample     gyro_x;
    t_sample     gyro_y;
    t_sample     gyro_z;
    logic [15:0] step_time;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, step_time,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, step_time,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/qaf_out_if.sv =====
// Output channel of the attitude filter: the attitude quaternion in Q1.30.
// Depends on qaf_pkg for the component type.
`timescale 1ns / 1ps
`default_nettype none

interface qaf_out_if;
    import qaf_pkg::*;

    logic  valid;
    logic  ready;
    t_comp quat_w;
    t_comp quat_x;
    t_comp quat_y;
    t_comp quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input  valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qaf_mac.sv =====
// Shared multiply-accumulate unit: registered 33x33 product, then accumulate.
// Depends on qaf_pkg for the micro-operation type and widths.
`timescale 1ns / 1ps
`default_nettype none

module qaf_mac (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire qaf_pkg::t_mac_op                i_op,
    output logic signed [qaf_pkg::ACC_W-1:0]     o_acc
);
    import qaf_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_en;
    logic                     r_clr;
    logic                     r_neg;
    logic                     r_sh30;
    logic signed [PROD_W-1:0] w_term;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  r_acc;

    assign w_prod = $signed(i_op.a) * $signed(i_op.b);

    // Floor by 2^30 where asked, then apply the sign of the term
    always_comb begin
        w_term = r_sh30 ? (r_prod >>> 30) : r_prod;
        if (r_neg) begin
            w_term = -w_term;
        end
        w_base = r_clr ? '0 : r_acc;
    end

    // Product stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_op.en;
        end
        if (i_op.en) begin
            r_prod <= w_prod;
            r_clr  <= i_op.clr;
            r_neg  <= i_op.neg;
            r_sh30 <= i_op.sh30;
        end
        if (r_en) begin
            r_acc <= w_base + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== hw/rtl/qaf_sqrt.sv =====
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module qaf_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [34:0] r_rem;
    logic [63:0] r_op;
    logic [31:0] r_root;
    logic [34:0] w_cand;
    logic [34:0] w_trial;
    logic        w_ge;

    // Bring down two bits and try the next root bit
    assign w_cand  = {r_rem[32:0], r_op[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_cand >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_op   <= i_val;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_cand - w_trial) : w_cand;
                r_root <= {r_root[30:0], w_ge};
                r_op   <= {r_op[61:0], 2'b00};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hw/rtl/qaf_div.sv =====
// Iterative restoring divider: 64-bit dividend by 32-bit divisor, 32 quotient
// bits, one per cycle. The quotient must fit in 32 bits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qaf_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quo
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_den;
    logic [31:0] r_quo;
    logic [32:0] w_t;
    logic [32:0] w_diff;
    logic        w_ge;

    // Shift in the next dividend bit and subtract where it fits
    assign w_t    = {r_rem, r_low[31]};
    assign w_diff = w_t - {1'b0, r_den};
    assign w_ge   = (w_t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num[63:32];
                r_low  <= i_num[31:0];
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_t[31:0];
                r_low <= {r_low[30:0], 1'b0};
                r_quo <= {r_quo[30:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_attitude_filter.sv =====
// Quaternion attitude filter (complementary filter with gyro bias estimate).
// Input channel i_in: valid/ready transfer of one accel and gyro sample and a
// Q0.16 time step. Output channel o_out: one Q1.30 attitude per input item.
// Configuration: i_cfg_we with i_cfg_idx 0 filter mode, 1 gain (Q8.8),
// 2 run enable; write only while the block is idle.
// One item at a time: i_in.ready is high only in the idle state. All
// products, square roots and divisions run on one registered 33x33
// multiply-accumulate unit, one 32-step square root unit and one 32-step
// divider under a sequencer. The time from transfer to result valid
// depends on the mode: in hold mode or when disabled the item goes straight
// to the output state, gyro-only mode and a zero acceleration skip the
// gravity correction, and the square root and the per-component divisions
// take most of the rest. The next item can be taken in the cycle after the
// result is loaded. The result sits in an output register; a new item is
// taken while it waits, and the sequencer stalls only when it must load the
// next result while the previous one is still not taken.
// Reset (synchronous, active low) sets the attitude to identity, the bias to
// zero, mode to gyro only, gain to 1.0 and run enable off.
// Depends on qaf_pkg, qaf_in_if, qaf_out_if, qaf_mac, qaf_sqrt and qaf_div.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_attitude_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    qaf_in_if.sink           i_in,
    qaf_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import qaf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAG, S_SQA, S_NORM, S_GRAV, S_ERR, S_GAIN, S_BIAS,
        S_RATE, S_HALF, S_PROP, S_SUMSQ, S_SQQ, S_RENORM, S_OUT
    } t_state;

    t_state      r_state;
    logic [2:0]  r_t;
    logic [1:0]  r_i;

    // Configuration
    logic [1:0]  r_mode;
    logic [15:0] r_kp;
    logic        r_run;

    // Filter state and working registers
    t_comp       r_q    [4];
    t_comp       r_bias [3];
    t_sample     r_a    [3];
    t_sample     r_g    [3];
    logic [15:0] r_dt;
    t_comp       r_n    [3];
    t_comp       r_v    [3];
    t_comp       r_e    [3];
    t_comp       r_c    [3];
    t_comp       r_h    [3];
    t_comp       r_nq   [4];
    logic [63:0] r_sq_in;
    logic [31:0] r_root;

    // Output register
    logic        r_out_valid;
    t_comp       r_oq   [4];

    // Shared units
    t_mac_op                  w_op;
    logic signed [ACC_W-1:0]  w_acc;
    logic                     w_sq_start;
    logic                     w_sq_done;
    logic [31:0]              w_sq_root;
    logic                     w_div_start;
    logic [63:0]              w_div_num;
    logic                     w_div_done;
    logic [31:0]              w_quo;
    logic [16:0]              w_abs_a;
    logic [31:0]              w_abs_nq;

    // Write-back values
    logic signed [67:0]       w_acc68;
    logic signed [67:0]       w_acc2;
    logic signed [67:0]       w_v2;
    logic signed [67:0]       w_bsum;
    logic signed [67:0]       w_nsum;
    t_comp                    w_nq;
    logic signed [ACC_W-1:0]  w_sh16;
    logic signed [ACC_W-1:0]  w_sh17;
    logic signed [ACC_W-1:0]  w_sh18;
    logic signed [ACC_W-1:0]  w_sh20;
    t_comp                    w_rate [3];
    logic                     w_accept;

    function automatic t_comp sat32(input logic signed [67:0] v);
        t_comp res;
        if (v > 68'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [OPND_W-1:0] s33(input t_comp v);
        return OPND_W'(v);
    endfunction

    qaf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_acc   (w_acc)
    );

    qaf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    qaf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_root),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Start the square root and divider on the first cycle of their states
    assign w_sq_start  = ((r_state == S_SQA) || (r_state == S_SQQ)) && (r_t == 3'd0);
    assign w_div_start = ((r_state == S_NORM) || (r_state == S_RENORM)) && (r_t == 3'd0);

    // Divider dividend: magnitude scaled up, sign applied on write-back
    always_comb begin
        w_abs_a  = r_a[r_i][15] ? (17'd0 - 17'(r_a[r_i])) : 17'(r_a[r_i]);
        w_abs_nq = r_nq[r_i][31] ? (32'd0 - r_nq[r_i]) : r_nq[r_i];
        if (r_state == S_NORM) begin
            w_div_num = 64'(w_abs_a) << 46;
        end else begin
            w_div_num = 64'(w_abs_nq) << 30;
        end
    end

    // Select the operands of the next product
    always_comb begin
        w_op = '0;
        case (r_state)
            S_MAG: begin
                w_op.en  = (r_t < 3'd3);
                w_op.clr = (r_t == 3'd0);
                w_op.a   = OPND_W'(r_a[r_t[1:0]]);
                w_op.b   = OPND_W'(r_a[r_t[1:0]]);
            end
            S_GRAV: begin
                w_op.en   = (r_t < 3'd2);
                w_op.clr  = (r_t == 3'd0);
                w_op.sh30 = 1'b1;
                case (r_i)
                    2'd0: begin
                        w_op.a = r_t[0] ? s33(r_q[0]) : s33(r_q[1]);
                        w_op.b = r_t[0] ? s33(r_q[2]) : s33(r_q[3]);
                    end
                    2'd1: begin
                        w_op.a   = r_t[0] ? s33(r_q[0]) : s33(r_q[2]);
                        w_op.b   = r_t[0] ? s33(r_q[1]) : s33(r_q[3]);
                        w_op.neg = r_t[0];
                    end
                    default: begin
                        w_op.a = r_t[0] ? s33(r_q[2]) : s33(r_q[1]);
                        w_op.b = r_t[0] ? s33(r_q[2]) : s33(r_q[1]);
                    end
                endcase
            end
            S_ERR: begin
                w_op.en   = (r_t < 3'd2);
                w_op.clr  = (r_t == 3'd0);
                w_op.sh30 = 1'b1;
                w_op.neg  = r_t[0];
                case (r_i)
                    2'd0: begin
                        w_op.a = r_t[0] ? s33(r_v[2]) : s33(r_v[1]);
                        w_op.b = r_t[0] ? s33(r_n[1]) : s33(r_n[2]);
                    end
                    2'd1: begin
                        w_op.a = r_t[0] ? s33(r_v[0]) : s33(r_v[2]);
                        w_op.b = r_t[0] ? s33(r_n[2]) : s33(r_n[0]);
                    end
                    default: begin
                        w_op.a = r_t[0] ? s33(r_v[1]) : s33(r_v[0]);
                        w_op.b = r_t[0] ? s33(r_n[0]) : s33(r_n[1]);
                    end
                endcase
            end
            S_GAIN: begin
                w_op.en  = (r_t == 3'd0);
                w_op.clr = 1'b1;
                w_op.a   = s33(r_e[r_i]);
                w_op.b   = {17'd0, r_kp};
            end
            S_BIAS: begin
                w_op.en  = (r_t == 3'd0);
                w_op.clr = 1'b1;
                w_op.a   = s33(r_c[r_i]);
                w_op.b   = {17'd0, r_dt};
            end
            S_HALF: begin
                w_op.en  = (r_t == 3'd0);
                w_op.clr = 1'b1;
                w_op.a   = s33(r_h[r_i]);
                w_op.b   = {17'd0, r_dt};
            end
            S_PROP: begin
                w_op.en  = (r_t < 3'd3);
                w_op.clr = (r_t == 3'd0);
                w_op.a   = s33(r_h[r_t[1:0]]);
                case (r_i)
                    2'd0: begin
                        w_op.neg = 1'b1;
                        case (r_t[1:0])
                            2'd0:    w_op.b = s33(r_q[1]);
                            2'd1:    w_op.b = s33(r_q[2]);
                            default: w_op.b = s33(r_q[3]);
                        endcase
                    end
                    2'd1: begin
                        w_op.neg = (r_t[1:0] == 2'd2);
                        case (r_t[1:0])
                            2'd0:    w_op.b = s33(r_q[0]);
                            2'd1:    w_op.b = s33(r_q[3]);
                            default: w_op.b = s33(r_q[2]);
                        endcase
                    end
                    2'd2: begin
                        w_op.neg = (r_t[1:0] == 2'd0);
                        case (r_t[1:0])
                            2'd0:    w_op.b = s33(r_q[3]);
                            2'd1:    w_op.b = s33(r_q[0]);
                            default: w_op.b = s33(r_q[1]);
                        endcase
                    end
                    default: begin
                        w_op.neg = (r_t[1:0] == 2'd1);
                        case (r_t[1:0])
                            2'd0:    w_op.b = s33(r_q[2]);
                            2'd1:    w_op.b = s33(r_q[1]);
                            default: w_op.b = s33(r_q[0]);
                        endcase
                    end
                endcase
            end
            S_SUMSQ: begin
                w_op.en  = (r_t < 3'd4);
                w_op.clr = (r_t == 3'd0);
                w_op.a   = s33(r_nq[r_t[1:0]]);
                w_op.b   = s33(r_nq[r_t[1:0]]);
            end
            default: begin
                w_op = '0;
            end
        endcase
    end

    // Write-back arithmetic on the accumulator
    always_comb begin
        w_acc68 = w_acc;
        w_acc2  = {w_acc[ACC_W-1], w_acc, 1'b0};
        w_v2    = 68'sd1073741824 - w_acc2;
        w_sh16  = w_acc >>> 16;
        w_sh17  = w_acc >>> 17;
        w_sh18  = w_acc >>> 18;
        w_sh20  = w_acc >>> 20;
        w_bsum  = 68'(r_bias[r_i]) + 68'(w_sh16);
        w_nsum  = 68'(r_q[r_i]) + 68'(w_sh20);
        if (w_nsum > 68'sd2147483647) begin
            w_nq = 32'sh7FFFFFFF;
        end else if (w_nsum < -68'sd2147483647) begin
            w_nq = 32'sh80000001;
        end else begin
            w_nq = w_nsum[31:0];
        end
        for (int k = 0; k < 3; k++) begin
            w_rate[k] = sat32(68'(r_bias[k]) + 68'(r_c[k]) - (68'(r_g[k]) <<< 10));
        end
    end

    assign w_accept = i_in.valid && (r_state == S_IDLE);

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_t         <= '0;
            r_i         <= '0;
            r_mode      <= MODE_GYRO;
            r_kp        <= GAIN_RESET;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
            r_q[0]      <= 32'sh40000000;
            r_q[1]      <= '0;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
            r_bias[0]   <= '0;
            r_bias[1]   <= '0;
            r_bias[2]   <= '0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: r_mode <= i_cfg_data[1:0];
                    CFG_GAIN: r_kp   <= i_cfg_data;
                    CFG_RUN:  r_run  <= i_cfg_data[0];
                    default:  ;
                endcase
            end

            // Drop the result once transferred, unless a new one replaces it
            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_a[0] <= i_in.accel_x;
                        r_a[1] <= i_in.accel_y;
                        r_a[2] <= i_in.accel_z;
                        r_g[0] <= i_in.gyro_x;
                        r_g[1] <= i_in.gyro_y;
                        r_g[2] <= i_in.gyro_z;
                        r_dt   <= i_in.step_time;
                        r_c[0] <= '0;
                        r_c[1] <= '0;
                        r_c[2] <= '0;
                        r_t    <= '0;
                        r_i    <= '0;
                        if (!r_run || !(r_mode inside {MODE_GYRO, MODE_CORR})) begin
                            r_state <= S_OUT;
                        end else if (r_mode == MODE_CORR) begin
                            r_state <= S_MAG;
                        end else begin
                            r_state <= S_RATE;
                        end
                    end
                end
                S_MAG: begin
                    if (r_t == 3'd4) begin
                        r_t <= '0;
                        if (w_acc[31:0] == 32'd0) begin
                            r_state <= S_RATE;
                        end else begin
                            r_sq_in <= {w_acc[31:0], 32'd0};
                            r_state <= S_SQA;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_SQA: begin
                    if (r_t == 3'd0) begin
                        r_t <= 3'd1;
                    end else if (w_sq_done) begin
                        r_root  <= w_sq_root;
                        r_t     <= '0;
                        r_i     <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_t == 3'd0) begin
                        r_t <= 3'd1;
                    end else if (w_div_done) begin
                        r_n[r_i] <= r_a[r_i][15] ? (32'd0 - w_quo) : w_quo;
                        r_t      <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_GRAV;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_GRAV: begin
                    if (r_t == 3'd3) begin
                        r_v[r_i] <= (r_i == 2'd2) ? sat32(w_v2) : sat32(w_acc2);
                        r_t      <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_ERR;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_ERR: begin
                    if (r_t == 3'd3) begin
                        r_e[r_i] <= sat32(w_acc68);
                        r_t      <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_GAIN;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_GAIN: begin
                    if (r_t == 3'd2) begin
                        r_c[r_i] <= w_sh18[31:0];
                        r_t      <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_BIAS;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_BIAS: begin
                    if (r_t == 3'd2) begin
                        r_bias[r_i] <= sat32(w_bsum);
                        r_t         <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_RATE;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_RATE: begin
                    // Corrected rate, held in the half-step registers
                    r_h[0]  <= w_rate[0];
                    r_h[1]  <= w_rate[1];
                    r_h[2]  <= w_rate[2];
                    r_t     <= '0;
                    r_i     <= '0;
                    r_state <= S_HALF;
                end
                S_HALF: begin
                    if (r_t == 3'd2) begin
                        r_h[r_i] <= w_sh17[31:0];
                        r_t      <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_PROP;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_PROP: begin
                    if (r_t == 3'd4) begin
                        r_nq[r_i] <= w_nq;
                        r_t       <= '0;
                        if (r_i == 2'd3) begin
                            r_i     <= '0;
                            r_state <= S_SUMSQ;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_SUMSQ: begin
                    if (r_t == 3'd5) begin
                        r_t <= '0;
                        if (w_acc[63:0] == 64'd0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_sq_in <= w_acc[63:0];
                            r_state <= S_SQQ;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                end
                S_SQQ: begin
                    if (r_t == 3'd0) begin
                        r_t <= 3'd1;
                    end else if (w_sq_done) begin
                        r_root  <= w_sq_root;
                        r_t     <= '0;
                        r_i     <= '0;
                        r_state <= S_RENORM;
                    end
                end
                S_RENORM: begin
                    if (r_t == 3'd0) begin
                        r_t <= 3'd1;
                    end else if (w_div_done) begin
                        r_q[r_i] <= r_nq[r_i][31] ? (32'd0 - w_quo) : w_quo;
                        r_t      <= '0;
                        if (r_i == 2'd3) begin
                            r_i     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    // Load the result once the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_oq[0]     <= r_q[0];
                        r_oq[1]     <= r_q[1];
                        r_oq[2]     <= r_q[2];
                        r_oq[3]     <= r_q[3];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.quat_w = r_oq[0];
    assign o_out.quat_x = r_oq[1];
    assign o_out.quat_y = r_oq[2];
    assign o_out.quat_z = r_oq[3];

endmodule

`default_nettype wire

// ===== test/qaf_checker.sv =====
// Checker of the quaternion attitude filter: watches both channels and the
// register write port, predicts every attitude and compares each transfer.
// Depends on qaf_pkg, qaf_in_if and qaf_out_if.
`timescale 1ns / 1ps

module qaf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qaf_in_if           in_ch,
    qaf_out_if          out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import qaf_pkg::*;

    typedef struct {
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_attitude;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    t_attitude   attitude_queue[$];
    t_comp       att[4];
    t_comp       bias[3];
    logic [1:0]  mode;
    logic [15:0] gain;
    logic        run;

    function automatic longint sat32(longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    function automatic longint mul30(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Advance the attitude and bias by one sample
    task automatic update_attitude(input longint a[3], input longint g[3], input longint dt);
        longint c[3];
        longint h[3];
        longint nq[4];
        longint n[3];
        longint v[3];
        longint e[3];
        longint w, x, y, z, r;
        longint unsigned m2, mag, s;
        w = att[0]; x = att[1]; y = att[2]; z = att[3];
        c = '{0, 0, 0};
        if (mode == MODE_CORR) begin
            m2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            if (m2 != 0) begin
                mag = int_sqrt(m2 << 32);
                for (int i = 0; i < 3; i++)
                    n[i] = (a[i] * (64'sd1 <<< 46)) / longint'(mag);
                v[0] = sat32(2 * (mul30(x, z) + mul30(w, y)));
                v[1] = sat32(2 * (mul30(y, z) - mul30(w, x)));
                v[2] = sat32(ONE_Q30 - 2 * (mul30(x, x) + mul30(y, y)));
                e[0] = sat32(mul30(v[1], n[2]) - mul30(v[2], n[1]));
                e[1] = sat32(mul30(v[2], n[0]) - mul30(v[0], n[2]));
                e[2] = sat32(mul30(v[0], n[1]) - mul30(v[1], n[0]));
                for (int i = 0; i < 3; i++) begin
                    c[i] = (e[i] * longint'(gain)) >>> 18;
                    bias[i] = t_comp'(sat32(longint'(bias[i]) + ((c[i] * dt) >>> 16)));
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            r = sat32(-g[i] * 1024 + longint'(bias[i]) + c[i]);
            h[i] = (r * dt) >>> 17;
        end
        nq[0] = w + ((-h[0] * x - h[1] * y - h[2] * z) >>> 20);
        nq[1] = x + ((h[0] * w + h[1] * z - h[2] * y) >>> 20);
        nq[2] = y + ((-h[0] * z + h[1] * w + h[2] * x) >>> 20);
        nq[3] = z + ((h[0] * y - h[1] * x + h[2] * w) >>> 20);
        s = 0;
        for (int i = 0; i < 4; i++) begin
            if (nq[i] > MAX32) nq[i] = MAX32;
            if (nq[i] < -MAX32) nq[i] = -MAX32;
            s = s + unsigned'(nq[i] * nq[i]);
        end
        // Keep the old attitude on a zero norm
        if (s != 0) begin
            mag = int_sqrt(s);
            for (int i = 0; i < 4; i++)
                att[i] = t_comp'(sat32((nq[i] * ONE_Q30) / longint'(mag)));
        end
    endtask

    assign o_pending = attitude_queue.size();

    always @(posedge i_clk) begin
        t_attitude exp_att;
        longint a[3];
        longint g[3];
        if (!i_rst_n) begin
            att = '{32'sd1073741824, 0, 0, 0};
            bias = '{0, 0, 0};
            mode = MODE_GYRO;
            gain = GAIN_RESET;
            run = 1'b0;
            attitude_queue.delete();
            o_fail_count = 0;
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: mode = i_cfg_data[1:0];
                    CFG_GAIN: gain = i_cfg_data;
                    CFG_RUN:  run = i_cfg_data[0];
                    default: ;
                endcase
            end
            // Predict on each input transfer
            if (in_ch.valid && in_ch.ready) begin
                a = '{longint'(in_ch.accel_x), longint'(in_ch.accel_y),
                      longint'(in_ch.accel_z)};
                g = '{longint'(in_ch.gyro_x), longint'(in_ch.gyro_y),
                      longint'(in_ch.gyro_z)};
                if (run && (mode == MODE_GYRO || mode == MODE_CORR))
                    update_attitude(a, g, longint'(in_ch.step_time));
                exp_att.w = att[0];
                exp_att.x = att[1];
                exp_att.y = att[2];
                exp_att.z = att[3];
                attitude_queue.push_back(exp_att);
            end
            // Compare each output transfer with the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (attitude_queue.size() == 0) begin
                    $error("unexpected attitude transfer");
                    o_fail_count++;
                end else begin
                    exp_att = attitude_queue.pop_front();
                    if (out_ch.quat_w !== exp_att.w) begin
                        $error("quat_w expected %0d actual %0d", exp_att.w, out_ch.quat_w);
                        o_fail_count++;
                    end
                    if (out_ch.quat_x !== exp_att.x) begin
                        $error("quat_x expected %0d actual %0d", exp_att.x, out_ch.quat_x);
                        o_fail_count++;
                    end
                    if (out_ch.quat_y !== exp_att.y) begin
                        $error("quat_y expected %0d actual %0d", exp_att.y, out_ch.quat_y);
                        o_fail_count++;
                    end
                    if (out_ch.quat_z !== exp_att.z) begin
                        $error("quat_z expected %0d actual %0d", exp_att.z, out_ch.quat_z);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb.sv =====
// Top of the attitude filter testbench: clock, reset, stimulus and verdict.
// Depends on qaf_pkg, qaf_in_if, qaf_out_if, qaf_checker and the block.
`timescale 1ns / 1ps

module tb;
    import qaf_pkg::*;

    // Hold codes of the filter mode
    localparam logic [1:0] MODE_HOLD = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          tx_idle;
    int          rx_idle;

    qaf_in_if  in_ch();
    qaf_out_if out_ch();

    quaternion_attitude_filter u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    qaf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every predicted attitude has arrived
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz, dt);
        if ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.accel_x <= ax;
        in_ch.accel_y <= ay;
        in_ch.accel_z <= az;
        in_ch.gyro_x <= gx;
        in_ch.gyro_y <= gy;
        in_ch.gyro_z <= gz;
        in_ch.step_time <= dt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_value(int span);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Mostly plausible motion, some full-range noise and some free fall
    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_sample(near_value(3000), near_value(3000), 16'(4096 + near_value(1500)),
                        near_value(3000), near_value(3000), near_value(3000),
                        16'($urandom_range(700)));
        else if (pick < 95)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_sample(16'd0, 16'd0, 16'd0, near_value(2000), near_value(2000),
                        near_value(2000), 16'($urandom_range(700)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_MODE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        in_ch.gyro_x = '0;
        in_ch.gyro_y = '0;
        in_ch.gyro_z = '0;
        in_ch.step_time = '0;
        tx_idle = 27;
        rx_idle = 48;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: disabled after reset, then each mode and gain extreme
        send_sample(16'h7fff, 16'h8000, 16'h1000, 16'h7fff, 16'h8000, 16'h0400, 16'hffff);
        drain();
        write_reg(CFG_RUN, 16'd1);
        send_sample(16'd0, 16'd0, 16'h1000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
        send_sample(16'd0, 16'd0, 16'h1000, 16'h8000, 16'h7fff, 16'h8000, 16'd0);
        send_sample(16'd0, 16'd0, 16'h1000, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
        drain();
        write_reg(CFG_MODE, 16'(MODE_CORR));
        send_sample(16'h1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100);
        send_sample(16'd0, 16'd0, 16'd0, 16'h0100, 16'd0, 16'd0, 16'h0100);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd0, 16'd0, 16'hffff);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        send_sample(16'h0001, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'h0200);
        drain();
        write_reg(CFG_GAIN, 16'hffff);
        send_sample(16'h0800, 16'hf000, 16'h0400, 16'd0, 16'h0040, 16'd0, 16'hffff);
        send_sample(16'hf800, 16'h1000, 16'hfc00, 16'h0040, 16'd0, 16'd0, 16'h8000);
        drain();
        write_reg(CFG_GAIN, 16'd0);
        send_sample(16'h0800, 16'h0800, 16'h0800, 16'h0010, 16'h0020, 16'h0030, 16'h1000);
        drain();
        write_reg(CFG_MODE, 16'(MODE_HOLD));
        send_sample(16'h1000, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'hffff);
        drain();
        write_reg(CFG_MODE, 16'(MODE_RSVD));
        send_sample(16'h1000, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'hffff);
        drain();

        // Random phases under changing settings and idling profiles
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                tx_idle = 48;
                rx_idle = 27;
            end else if (ph == 8) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            write_reg(CFG_MODE, 16'(($urandom_range(9) < 6) ? MODE_CORR :
                      2'($urandom_range(3))));
            case ($urandom_range(3))
                0: write_reg(CFG_GAIN, 16'd0);
                1: write_reg(CFG_GAIN, 16'hffff);
                default: write_reg(CFG_GAIN, 16'($urandom_range(1024)));
            endcase
            write_reg(CFG_RUN, 16'($urandom_range(9) != 0));
            repeat (94) send_random();
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("quaternion_attitude_filter test passed");
        else
            $display("quaternion_attitude_filter test failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("quaternion_attitude_filter test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/qaf_pkg.sv
hw/rtl/qaf_in_if.sv
hw/rtl/qaf_out_if.sv
hw/rtl/qaf_mac.sv
hw/rtl/qaf_sqrt.sv
hw/rtl/qaf_div.sv
hw/rtl/quaternion_attitude_filter.sv
test/qaf_checker.sv
test/tb.sv
